### src/dst_pkg.sv
`timescale 1ns / 1ps

package dst_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 64;
    localparam int WORD_W     = 64;
    localparam int KEY_WORDS  = 4;
    localparam int KEY_W      = WORD_W * KEY_WORDS;
    localparam int SLOT_OUT_W = 6;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 3;

    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [COUNT_W-1:0] t_count;

    // Operation carried by an input item.
    typedef enum logic {
        FUNC_CLAIM   = 1'b0,
        FUNC_RELEASE = 1'b1
    } t_func;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_CLAIMED   = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_RELEASED  = 3'd3,
        STAT_MISS      = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } t_state;

    // Priority flags rippled from the low end of the row to the high end.
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } t_chain;

    // Update broadcast to every cell; only the selected cell acts on it.
    typedef struct packed {
        logic claim;
        logic release_key;
    } t_cell_cmd;

    // Which role a cell holds in the current search.
    typedef struct packed {
        logic first_hit;
        logic first_free;
    } t_cell_pick;

endpackage

### src/dst_if.sv
`timescale 1ns / 1ps

interface dst_in_if;
    import dst_pkg::*;
    logic                valid;
    logic                ready;
    logic [0:0]          func;
    logic [WORD_W-1:0]   key_word0;
    logic [WORD_W-1:0]   key_word1;
    logic [WORD_W-1:0]   key_word2;
    logic [WORD_W-1:0]   key_word3;

    modport source (output valid, output func, output key_word0, output key_word1,
                    output key_word2, output key_word3, input ready);
    modport sink   (input valid, input func, input key_word0, input key_word1,
                    input key_word2, input key_word3, output ready);
endinterface

interface dst_out_if;
    import dst_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [COUNT_W-1:0]    active_count;

    modport source (output valid, output status, output slot_index, output active_count,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input active_count,
                    output ready);
endinterface

### src/dedup_slot_table_top.sv
`timescale 1ns / 1ps

// Deduplicating slot table. The block keeps SLOT_COUNT slots, each a cell that
// holds a 256-bit job key and a valid bit, arranged as a row. A claim item
// returns the lowest valid slot that already holds the key (status duplicate),
// or else stores the key in the lowest free slot (status claimed new), or
// reports table full. A release item frees the lowest valid slot holding the
// key (status released) or reports a release miss. Every item yields exactly
// one result item carrying the status, the slot number (zero on full or miss)
// and the number of valid slots after the item. In the cycle an item is
// accepted every cell compares its stored key with the incoming one and
// registers the match; then, in the resolve state, the match and free flags
// ripple along the row to pick the lowest hit and lowest free cell, and once
// the output register is empty or being drained the chosen cell is updated
// and the result is written to the output register. The input is ready again
// only back in the idle state, so a new item is not taken until the last one
// is resolved. A result waiting in the output register does not block
// acceptance of the next item; only the resolve step waits for the register to drain.
module dedup_slot_table_top
    import dst_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    dst_in_if.sink    i_in,
    dst_out_if.source o_out
);

    t_state     r_state;
    t_state     n_state;
    t_func      r_func;
    t_key       r_key;
    t_count     r_count;
    t_count     n_count;

    logic                  r_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic [SLOT_OUT_W-1:0] n_slot;
    t_count                r_out_count;

    logic       w_load;
    logic       w_fire;
    t_key       w_in_key;
    t_cell_cmd  w_cmd;
    t_chain     w_chain [SLOT_COUNT+1];
    t_cell_pick w_pick  [SLOT_COUNT];
    logic       w_any_hit;
    logic       w_any_free;
    logic [SLOT_OUT_W-1:0] w_hit_idx;
    logic [SLOT_OUT_W-1:0] w_free_idx;

    assign w_in_key = {i_in.key_word3, i_in.key_word2, i_in.key_word1, i_in.key_word0};
    assign w_load   = i_in.valid && i_in.ready;

    // The row of cells. Priority flags enter at slot zero.
    assign w_chain[0] = '0;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        dst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load),
            .i_key   (w_in_key),
            .i_wkey  (r_key),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_pick  (w_pick[g])
        );
    end

    assign w_any_hit  = w_chain[SLOT_COUNT].hit_seen;
    assign w_any_free = w_chain[SLOT_COUNT].free_seen;

    // At most one cell holds each pick, so the slot numbers can be OR-ed.
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (w_pick[i].first_hit) begin
                w_hit_idx = w_hit_idx | SLOT_OUT_W'(i);
            end
            if (w_pick[i].first_free) begin
                w_free_idx = w_free_idx | SLOT_OUT_W'(i);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        i_in.ready = 1'b0;
        w_fire     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_RESOLVE: begin
                w_fire = !r_out_valid || o_out.ready;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
        w_cmd.claim       = w_fire && (r_func == FUNC_CLAIM) && !w_any_hit && w_any_free;
        w_cmd.release_key = w_fire && (r_func == FUNC_RELEASE) && w_any_hit;
    end

    // Result of the item being resolved.
    always_comb begin
        n_status = STAT_MISS;
        n_slot   = '0;
        n_count  = r_count;
        if (r_func == FUNC_CLAIM) begin
            if (w_any_hit) begin
                n_status = STAT_DUPLICATE;
                n_slot   = w_hit_idx;
            end else if (w_any_free) begin
                n_status = STAT_CLAIMED;
                n_slot   = w_free_idx;
                n_count  = r_count + 1'b1;
            end else begin
                n_status = STAT_FULL;
            end
        end else begin
            if (w_any_hit) begin
                n_status = STAT_RELEASED;
                n_slot   = w_hit_idx;
                n_count  = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_func <= t_func'(i_in.func);
            r_key  <= w_in_key;
        end
        if (w_fire) begin
            r_status    <= n_status;
            r_slot      <= n_slot;
            r_out_count <= n_count;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.slot_index   = r_slot;
    assign o_out.active_count = r_out_count;

endmodule

### src/dst_cell.sv
`timescale 1ns / 1ps

module dst_cell
    import dst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_key       i_key,
    input  t_key       i_wkey,
    input  t_cell_cmd  i_cmd,
    input  t_chain     i_chain,
    output t_chain     o_chain,
    output t_cell_pick o_pick
);

    logic r_valid;
    logic n_valid;
    logic r_hit;
    t_key r_key;

    // The compare result is captured when the item is taken in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_load) begin
            r_hit <= r_valid && (r_key == i_key);
        end
    end

    always_comb begin
        o_pick.first_hit  = r_hit && !i_chain.hit_seen;
        o_pick.first_free = !r_valid && !i_chain.free_seen;
        o_chain.hit_seen  = i_chain.hit_seen || r_hit;
        o_chain.free_seen = i_chain.free_seen || !r_valid;
    end

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.claim && o_pick.first_free) begin
            n_valid = 1'b1;
        end else if (i_cmd.release_key && o_pick.first_hit) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.claim && o_pick.first_free) begin
            r_key <= i_wkey;
        end
    end

endmodule

### src/dst_checker.sv
`timescale 1ns / 1ps

module dst_checker
    import dst_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [STATUS_W-1:0]   i_status,
    input logic [SLOT_OUT_W-1:0] i_slot_index,
    input logic [COUNT_W-1:0]    i_active_count
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_slot_index) && $stable(i_active_count))
        else $error("result changed while stalled");

    // Full and miss results carry slot zero.
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == STAT_FULL || i_status == STAT_MISS)
            |-> i_slot_index == '0)
        else $error("full or miss result with nonzero slot");

    // The table reports full only when every slot is taken.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STAT_FULL |-> i_active_count == COUNT_W'(SLOT_COUNT))
        else $error("full result with slots still free");

    // Right after a release at least one slot is free.
    a_release_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STAT_RELEASED
            |-> i_active_count != COUNT_W'(SLOT_COUNT))
        else $error("release result with every slot taken");

endmodule

bind dedup_slot_table_top dst_checker u_dst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_slot_index   (o_out.slot_index),
    .i_active_count (o_out.active_count)
);
